### design/kedl_pkg.sv
// Shared types, constants and command codes of the keyed expiry table.
`timescale 1ns / 1ps
package kedl_pkg;
	localparam int CAPACITY_DEF  = 16;
	localparam int KEY_BITS_DEF  = 32;
	localparam int TIME_BITS_DEF = 16;
	localparam int LIFE_BITS     = 16;
	localparam logic [LIFE_BITS-1:0] LIFE_RESET = 16'd60;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_UPDATE = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_LOOKUP = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_code_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] key;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic        table_full;
		logic        expired;
		logic [31:0] expired_key;
		logic [4:0]  entry_count;
		logic        last;
	} out_item_t;
endpackage

### design/keyed_expiry_delta_list.sv
// Top level of the keyed expiry table kept as a delta list.
// The registered key search runs over all entries, then the list is updated and the result
// is written to the output register.
// A tick emits one result per expired entry, at most 16, or a single result if none expired.
// Results are held in an output register until taken; one item at a time.
// Asynchronous reset empties the table and sets the lifetime to 60 ticks.
`timescale 1ns / 1ps
module keyed_expiry_delta_list #(
	parameter int CAPACITY  = kedl_pkg::CAPACITY_DEF,
	parameter int KEY_BITS  = kedl_pkg::KEY_BITS_DEF,
	parameter int TIME_BITS = kedl_pkg::TIME_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  kedl_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output kedl_pkg::out_item_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [kedl_pkg::LIFE_BITS-1:0]       cfg_data
);
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MAXR = 16;
	localparam int RW = 5;
	localparam logic [TIME_BITS-1:0] TMAX = '1;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DISPATCH, S_UNLINK_A, S_UNLINK_B, S_APPEND_A,
		S_APPEND_B, S_TICK, S_EXP_A, S_EXP_B, S_OUT
	} state_t;

	logic [KEY_BITS-1:0]  key_mem [CAPACITY];
	logic [TIME_BITS-1:0] delta_mem [CAPACITY];
	logic [IW-1:0]        next_mem [CAPACITY];
	logic [IW-1:0]        prev_mem [CAPACITY];
	logic [CAPACITY-1:0]  valid_q;

	state_t state_q;
	logic [2:0] cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IW-1:0] head_q, tail_q, at_q, nb_q;
	logic [TIME_BITS-1:0] trem_q, dat_q;
	logic [CW-1:0] occ_q;
	logic [kedl_pkg::LIFE_BITS-1:0] life_q;
	logic [RW-1:0] nres_q;
	logic rm_valid_q, after_append_q, tick_mode_q;
	kedl_pkg::out_item_t out_q;
	logic out_valid_q;

	logic scan_start, scan_busy, hit, free_ok;
	logic [IW-1:0] scan_idx, hit_idx, free_idx;
	logic [KEY_BITS-1:0] rd_key_q;
	logic rd_valid_q;
	logic [TIME_BITS-1:0] lt;
	logic [kedl_pkg::LIFE_BITS-1:0] life_nz;

	always_comb begin
		life_nz = (life_q == '0) ? kedl_pkg::LIFE_BITS'(1) : life_q;
		if (TIME_BITS >= kedl_pkg::LIFE_BITS) begin
			lt = TIME_BITS'(life_nz);
		end else if ((life_nz >> TIME_BITS) != '0) begin
			lt = TMAX;
		end else begin
			lt = TIME_BITS'(life_nz);
		end
	end

	assign scan_start = (state_q == S_IDLE) && in_valid;
	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		rd_key_q <= key_mem[scan_idx];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_valid_q <= 1'b0;
		else rd_valid_q <= valid_q[scan_idx];
	end

	kedl_scan #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_scan (
		.clk(clk), .arst_n(arst_n), .start(scan_start),
		.key(scan_start ? KEY_BITS'(in_data.key) : key_q),
		.cur_key(rd_key_q), .cur_valid(rd_valid_q),
		.idx(scan_idx), .busy(scan_busy), .hit(hit), .hit_idx(hit_idx),
		.free_ok(free_ok), .free_idx(free_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			trem_q <= '0;
			occ_q <= '0;
			life_q <= kedl_pkg::LIFE_RESET;
			out_valid_q <= 1'b0;
			out_q <= '0;
			cmd_q <= '0;
			key_q <= '0;
			at_q <= '0;
			nb_q <= '0;
			dat_q <= '0;
			nres_q <= '0;
			rm_valid_q <= 1'b0;
			after_append_q <= 1'b0;
			tick_mode_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) life_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= in_data.cmd;
						key_q <= KEY_BITS'(in_data.key);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!scan_busy) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					if (!out_valid_q || out_ready) begin
						at_q <= hit_idx;
						out_q <= '0;
						out_q.last <= 1'b1;
						out_q.entry_count <= 5'(occ_q);
						state_q <= S_OUT;
						priority case (cmd_q)
							kedl_pkg::CMD_TICK: begin
								nres_q <= '0;
								if (occ_q != '0) begin
									at_q <= head_q;
									state_q <= S_TICK;
								end
							end
							kedl_pkg::CMD_INSERT, kedl_pkg::CMD_UPDATE: begin
								out_q.found <= hit;
								if (hit) begin
									if (cmd_q == kedl_pkg::CMD_UPDATE) begin
										rm_valid_q <= 1'b0;
										after_append_q <= 1'b1;
										tick_mode_q <= 1'b0;
										state_q <= S_UNLINK_A;
									end
								end else if (!free_ok) begin
									out_q.table_full <= 1'b1;
								end else begin
									at_q <= free_idx;
									valid_q[free_idx] <= 1'b1;
									key_mem[free_idx] <= key_q;
									state_q <= S_APPEND_A;
								end
							end
							kedl_pkg::CMD_REMOVE: begin
								out_q.found <= hit;
								if (hit) begin
									rm_valid_q <= 1'b1;
									after_append_q <= 1'b0;
									tick_mode_q <= 1'b0;
									state_q <= S_UNLINK_A;
								end
							end
							kedl_pkg::CMD_LOOKUP: out_q.found <= hit;
							kedl_pkg::CMD_CLEAR: begin
								valid_q <= '0;
								head_q <= '0;
								tail_q <= '0;
								trem_q <= '0;
								occ_q <= '0;
								out_q.entry_count <= '0;
							end
							default: ;
						endcase
					end
				end
				S_UNLINK_A: begin
					if (!tick_mode_q || !out_valid_q || out_ready) begin
						dat_q <= delta_mem[at_q];
						nb_q <= next_mem[at_q];
						state_q <= S_UNLINK_B;
					end
				end
				S_UNLINK_B: begin
					if (at_q != tail_q) begin
						delta_mem[nb_q] <= delta_mem[nb_q] + dat_q;
						prev_mem[nb_q] <= prev_mem[at_q];
					end else begin
						trem_q <= (trem_q >= dat_q) ? trem_q - dat_q : '0;
						if (at_q != head_q) tail_q <= prev_mem[at_q];
					end
					if (at_q != head_q) next_mem[prev_mem[at_q]] <= nb_q;
					else if (at_q != tail_q) head_q <= nb_q;
					occ_q <= occ_q - 1'b1;
					if (occ_q == CW'(1)) trem_q <= '0;
					if (rm_valid_q) valid_q[at_q] <= 1'b0;
					if (tick_mode_q) begin
						valid_q[at_q] <= 1'b0;
						out_q <= '0;
						out_q.expired <= 1'b1;
						out_q.expired_key <= 32'(key_mem[at_q]);
						out_q.entry_count <= 5'(occ_q - 1'b1);
						nres_q <= nres_q + 1'b1;
						state_q <= S_EXP_B;
					end else if (after_append_q) begin
						state_q <= S_APPEND_A;
					end else begin
						out_q.entry_count <= 5'(occ_q - 1'b1);
						state_q <= S_OUT;
					end
				end
				S_APPEND_A: begin
					if (occ_q == '0) begin
						delta_mem[at_q] <= lt;
						head_q <= at_q;
						trem_q <= lt;
					end else begin
						if (lt >= trem_q) begin
							delta_mem[at_q] <= lt - trem_q;
							trem_q <= lt;
						end else begin
							delta_mem[at_q] <= '0;
						end
						next_mem[tail_q] <= at_q;
						prev_mem[at_q] <= tail_q;
					end
					tail_q <= at_q;
					occ_q <= occ_q + 1'b1;
					out_q.entry_count <= 5'(occ_q + 1'b1);
					state_q <= S_OUT;
				end
				S_TICK: begin
					if (delta_mem[head_q] != '0) begin
						delta_mem[head_q] <= delta_mem[head_q] - 1'b1;
						if (trem_q != '0) trem_q <= trem_q - 1'b1;
					end
					state_q <= S_EXP_A;
				end
				S_EXP_A: begin
					if (occ_q != '0 && delta_mem[head_q] == '0 && nres_q != RW'(MAXR)) begin
						at_q <= head_q;
						rm_valid_q <= 1'b0;
						after_append_q <= 1'b0;
						tick_mode_q <= 1'b1;
						state_q <= S_UNLINK_A;
					end else begin
						tick_mode_q <= 1'b0;
						out_q <= '0;
						out_q.last <= 1'b1;
						out_q.entry_count <= 5'(occ_q);
						state_q <= (nres_q == '0) ? S_OUT : S_IDLE;
					end
				end
				S_EXP_B: begin
					if (!out_valid_q || out_ready) begin
						if (occ_q != '0 && delta_mem[head_q] == '0 && nres_q != RW'(MAXR)) begin
							out_valid_q <= 1'b1;
							out_q.last <= 1'b0;
							at_q <= head_q;
							state_q <= S_UNLINK_A;
						end else begin
							out_valid_q <= 1'b1;
							out_q.last <= 1'b1;
							tick_mode_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/kedl_scan.sv
// Sequential key and free-entry search, one entry compared per cycle.
`timescale 1ns / 1ps
module kedl_scan #(
	parameter int CAPACITY = kedl_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = kedl_pkg::KEY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [KEY_BITS-1:0]         key,
	input  logic [KEY_BITS-1:0]         cur_key,
	input  logic                        cur_valid,
	output logic [$clog2(CAPACITY)-1:0] idx,
	output logic                        busy,
	output logic                        hit,
	output logic [$clog2(CAPACITY)-1:0] hit_idx,
	output logic                        free_ok,
	output logic [$clog2(CAPACITY)-1:0] free_idx
);
	localparam int IW = $clog2(CAPACITY);
	localparam logic [IW-1:0] LAST_IX = IW'(CAPACITY - 1);
	logic [IW-1:0] idx_q;
	logic issue_q;
	logic cmp_s1;
	logic [IW-1:0] idx_s1;
	logic hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;

	assign idx = idx_q;
	assign busy = issue_q || cmp_s1;
	assign hit = hit_q;
	assign hit_idx = hit_idx_q;
	assign free_ok = free_q;
	assign free_idx = free_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			issue_q <= 1'b0;
			cmp_s1 <= 1'b0;
			idx_s1 <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
		end else if (start) begin
			idx_q <= '0;
			issue_q <= 1'b1;
			cmp_s1 <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
		end else begin
			cmp_s1 <= issue_q;
			idx_s1 <= idx_q;
			if (issue_q) begin
				if (idx_q == LAST_IX) begin
					issue_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (cmp_s1) begin
				if (cur_valid && cur_key == key && !hit_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= idx_s1;
				end
				if (!cur_valid && !free_q) begin
					free_q <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end
		end
	end
endmodule

### design/kedl_checker.sv
// Port checker for the keyed expiry table, bound to the top level.
`timescale 1ns / 1ps
module kedl_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input kedl_pkg::out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.entry_count <= 5'd16)
		else $error("entry count too large");
	a_exp_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.expired |-> out_data.expired_key == '0)
		else $error("key shown without expiry");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second item at once");
endmodule

bind keyed_expiry_delta_list kedl_checker u_kedl_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
